FILE: src/dqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and constants for the double-ended queue with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

   // default ring depth
   localparam int CAPACITY_DEF = 32;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;

   // operation codes carried on req_opcode
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4,
      OP_SEARCH     = 3'd5
   } opcode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage : dqs_pkg
`default_nettype wire

FILE: src/dqs_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_store
// Ring entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqs_store #(
   parameter int DEPTH  = dqs_pkg::CAPACITY_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [dqs_pkg::DATA_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [dqs_pkg::DATA_W-1:0] rd_data
);
   import dqs_pkg::*;

   logic [DATA_W-1:0] entry_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // read the entry; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : dqs_store
`default_nettype wire

FILE: src/dqs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_ctrl
// Operation sequencer: ring pointers, walk over the entry memory for dump and
// search, and the result register.
// ----------------------------------------------------------------------------
module dqs_ctrl #(
   parameter int CAPACITY = dqs_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request beat
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dqs_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [dqs_pkg::DATA_W-1:0]    req_value,
   // result beat
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [dqs_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [dqs_pkg::POS_W-1:0]     rsp_position,
   output logic      [dqs_pkg::DATA_W-1:0]    rsp_entry_data,
   output logic                               rsp_last,
   // entry memory
   output logic                               mem_wr_en,
   output logic      [IDX_W-1:0]              mem_wr_addr,
   output logic      [dqs_pkg::DATA_W-1:0]    mem_wr_data,
   output logic                               mem_rd_en,
   output logic      [IDX_W-1:0]              mem_rd_addr,
   input  wire logic [dqs_pkg::DATA_W-1:0]    mem_rd_data
);
   import dqs_pkg::*;

   localparam logic [IDX_W:0]   CAP_X    = (IDX_W+1)'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

   state_type          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                last_ff, last_in;

   logic               out_free;
   logic               load;
   logic               full;
   logic               empty;
   logic [IDX_W-1:0]   front_dec;
   logic [IDX_W-1:0]   front_inc;
   logic [IDX_W-1:0]   slot_inc;
   logic [IDX_W:0]     back_sum;
   logic [IDX_W-1:0]   back_slot;
   logic [CNT_W-1:0]   idx_next;
   logic               last_entry;

   // ring pointer arithmetic
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      full       = (count_ff == CAP_CNT);
      empty      = (count_ff == '0);
      front_dec  = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
      front_inc  = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
      slot_inc   = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
      back_sum   = (IDX_W+1)'(front_ff) + (IDX_W+1)'(count_ff);
      back_slot  = (back_sum >= CAP_X) ? IDX_W'(back_sum - CAP_X) : IDX_W'(back_sum);
      idx_next   = idx_ff + 1'b1;
      last_entry = (idx_next == count_ff);
   end

   // next state, pointer updates and result loading
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      load        = 1'b0;
      status_in   = STATUS_OK;
      position_in = '0;
      data_in     = '0;
      last_in     = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = back_slot;
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = slot_ff;
      req_ready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            // latch the beat; drop unused opcodes
            if (req_valid) begin
               op_in  = req_opcode;
               val_in = req_value;
               if (req_opcode <= OP_SEARCH) begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (op_ff == OP_PUSH_FRONT || op_ff == OP_PUSH_BACK) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                     if (op_ff == OP_PUSH_FRONT) begin
                        mem_wr_addr = front_dec;
                        front_in    = front_dec;
                     end
                  end
               end
            end else if (empty) begin
               // underflow on pops, dump and search
               if (out_free) begin
                  load      = 1'b1;
                  status_in = STATUS_UNDERFLOW;
                  state_in  = ST_IDLE;
               end
            end else if (op_ff == OP_POP_FRONT || op_ff == OP_POP_BACK) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
                  count_in = count_ff - 1'b1;
                  if (op_ff == OP_POP_FRONT) begin
                     front_in = front_inc;
                  end
               end
            end else begin
               // start the walk at the front entry
               idx_in   = '0;
               slot_in  = front_ff;
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end

         ST_CHECK: begin
            if (op_ff == OP_DUMP) begin
               // emit one entry per beat
               if (out_free) begin
                  load    = 1'b1;
                  data_in = mem_rd_data;
                  last_in = last_entry;
                  if (last_entry) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     slot_in  = slot_inc;
                     state_in = ST_READ;
                  end
               end
            end else if (mem_rd_data == val_ff) begin
               if (out_free) begin
                  load        = 1'b1;
                  position_in = POS_W'(idx_next);
                  state_in    = ST_IDLE;
               end
            end else if (last_entry) begin
               if (out_free) begin
                  load      = 1'b1;
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_IDLE;
               end
            end else begin
               idx_in   = idx_next;
               slot_in  = slot_inc;
               state_in = ST_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      if (load) begin
         status_ff   <= status_in;
         position_ff <= position_in;
         data_ff     <= data_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_position   = position_ff;
   assign rsp_entry_data = data_ff;
   assign rsp_last       = last_ff;

endmodule : dqs_ctrl
`default_nettype wire

FILE: src/deque_with_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with dump and search.
// ----------------------------------------------------------------------------
// The queue lives in a CAPACITY-entry ring memory with registered read data.
// Push and pop latch the request beat, then update the pointers and write the
// memory. Dump and search walk the memory from the front, reading each entry
// and then comparing or emitting it; dump delivers one result beat per entry.
// Every request beat except opcodes 6 and 7 gives results, with rsp_last on
// the final one; 6 and 7 are dropped. A pending result sits in an output
// register, so a new beat is taken while the previous result waits.
// ----------------------------------------------------------------------------
module deque_with_search #(
   parameter int CAPACITY = dqs_pkg::CAPACITY_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [dqs_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [dqs_pkg::DATA_W-1:0]   req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [dqs_pkg::STATUS_W-1:0] rsp_status,
   output logic             [dqs_pkg::POS_W-1:0]    rsp_position,
   output logic signed      [dqs_pkg::DATA_W-1:0]   rsp_entry_data,
   output logic                                     rsp_last
);
   import dqs_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;
   logic [DATA_W-1:0] entry_data;

   // sequencer
   dqs_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_data (entry_data),
      .rsp_last       (rsp_last),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // ring memory
   dqs_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_entry_data = $signed(entry_data);

endmodule : deque_with_search
`default_nettype wire

FILE: tb/deque_with_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_search_tb
// Self-checking bench for the double-ended queue with dump and search.
// A queue of request beats, filled up front, feeds a clocked driver. A clocked
// monitor keeps a shadow deque. For every accepted request it queues the
// expected result beats, and it checks each result beat against the oldest
// one. Both sides idle at random. The receiver stalls once for a long stretch,
// and the sender waits for a full drain at least once.
// ----------------------------------------------------------------------------
module deque_with_search_tb;
   import dqs_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 7;
   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 180;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 1_000_000;

   // opcodes the block drops without a result
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   // share of pushes in a burst of random requests
   localparam int PUSH_PCT_FILL  = 70;
   localparam int PUSH_PCT_MIXED = 40;
   localparam int PUSH_PCT_DRAIN = 15;

   typedef struct {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [DATA_W-1:0] value;
      int                       gap;
      bit                       drain;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] entry_data;
      logic                     last;
   } rsp_beat_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode     = '0;
   logic signed [DATA_W-1:0]   req_value      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [POS_W-1:0]           rsp_position;
   logic signed [DATA_W-1:0]   rsp_entry_data;
   logic                       rsp_last;

   // handshake flags sampled at the rising edge, read by the drivers
   bit                         req_fire = 1'b0;
   bit                         rsp_fire = 1'b0;
   bit                         hold_rsp = 1'b0;
   int                         accepted_count = 0;
   int                         mismatch_count = 0;

   request_type                pending_requests[$];
   rsp_beat_type               expected_beats[$];

   // shadow deque
   logic signed [DATA_W-1:0]   ring_copy [CAPACITY];
   int unsigned                front_slot;
   int unsigned                queue_len;

   // stimulus generation state
   bit                         gen_quiet;
   bit                         gen_drain;
   int                         gen_count;
   logic signed [DATA_W-1:0]   pushed_values[$];

   // driver and receiver state
   request_type                tx_item;
   int                         tx_wait = 0;
   int                         cur_gap = 0;
   int                         rx_gap = 0;
   int                         rx_mode_left = 0;
   bit                         rx_quiet = 1'b0;

   deque_with_search DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_data (rsp_entry_data),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // mostly short idles, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // random word, with a fair share of the extremes
   function automatic logic signed [DATA_W-1:0] any_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // search key: mostly a recently pushed word, so that hits are common
   function automatic logic signed [DATA_W-1:0] search_key();
      if (pushed_values.size() != 0 && $urandom_range(0, 9) < 7)
         return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
      return any_value();
   endfunction

   task automatic queue_request(input logic [OPCODE_W-1:0]      op,
                                input logic signed [DATA_W-1:0] val);
      request_type item;
      item.opcode = op;
      item.value  = val;
      item.gap    = gen_quiet ? 0 : idle_length();
      item.drain  = gen_drain;
      gen_drain   = 1'b0;
      pending_requests.push_back(item);
      if (op <= OP_SEARCH) gen_count++;
      // remember pushed words as future search keys
      if (op <= OP_PUSH_BACK) begin
         pushed_values.push_back(val);
         if (pushed_values.size() > 24) void'(pushed_values.pop_front());
      end
   endtask

   task automatic queue_random_op(input int push_pct);
      int                  roll;
      logic [OPCODE_W-1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (roll < push_pct + 15)
         op = OP_SEARCH;
      else if (roll < push_pct + 18)
         op = OP_DUMP;
      else
         op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      queue_request(op, (op == OP_SEARCH) ? search_key() : any_value());
   endtask

   // shadow deque: update state and queue the result beats of one request
   task automatic predict_request(input logic [OPCODE_W-1:0]      op,
                                  input logic signed [DATA_W-1:0] key);
      rsp_beat_type beat;
      int unsigned  k;
      bit           found;
      beat = '{status: STATUS_OK, position: '0, entry_data: '0, last: 1'b1};
      found = 1'b0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (queue_len >= CAPACITY) begin
            beat.status = STATUS_FULL;
         end else begin
            if (op == OP_PUSH_FRONT) begin
               front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
               ring_copy[front_slot] = key;
            end else begin
               ring_copy[(front_slot + queue_len) % CAPACITY] = key;
            end
            queue_len++;
         end
         expected_beats.push_back(beat);
      end else if (op <= OP_SEARCH) begin
         if (queue_len == 0) begin
            beat.status = STATUS_UNDERFLOW;
            expected_beats.push_back(beat);
         end else begin
            case (op)
               OP_POP_FRONT: begin
                  front_slot = (front_slot + 1) % CAPACITY;
                  queue_len--;
                  expected_beats.push_back(beat);
               end
               OP_POP_BACK: begin
                  queue_len--;
                  expected_beats.push_back(beat);
               end
               OP_DUMP: begin
                  for (k = 0; k < queue_len; k++) begin
                     beat.entry_data = ring_copy[(front_slot + k) % CAPACITY];
                     beat.last       = (k + 1 == queue_len);
                     expected_beats.push_back(beat);
                  end
               end
               default: begin
                  // first match from the front wins
                  for (k = 0; k < queue_len; k++) begin
                     if (!found && ring_copy[(front_slot + k) % CAPACITY] == key) begin
                        found         = 1'b1;
                        beat.position = POS_W'(k + 1);
                     end
                  end
                  if (!found) beat.status = STATUS_NOT_FOUND;
                  expected_beats.push_back(beat);
               end
            endcase
         end
      end
   endtask

   function automatic void check_field(input string       field,
                                       input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // monitor: check result beats, then predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         req_fire   <= 1'b0;
         rsp_fire   <= 1'b0;
         front_slot = 0;
         queue_len  = 0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t ns: result beat with none expected, status %0d data %0h",
                        $time, rsp_status, rsp_entry_data);
               mismatch_count++;
            end else begin
               check_field("status", 32'(expected_beats[0].status), 32'(rsp_status));
               check_field("position", 32'(expected_beats[0].position), 32'(rsp_position));
               check_field("entry_data", expected_beats[0].entry_data, rsp_entry_data);
               check_field("last", 32'(expected_beats[0].last), 32'(rsp_last));
               void'(expected_beats.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            accepted_count++;
            predict_request(req_opcode, req_value);
         end
      end
   end

   // driver: hold the beat until taken, then idle or offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait   = 0;
      end else if (!req_valid || req_fire) begin
         if (req_fire) tx_wait = cur_gap;
         if (tx_wait > 0) begin
            tx_wait--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain && expected_beats.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            tx_item = pending_requests.pop_front();
            cur_gap = tx_item.gap;
            req_valid  <= 1'b1;
            req_opcode <= tx_item.opcode;
            req_value  <= tx_item.value;
         end
      end
   end

   // receiver: random stalls, with calm stretches and the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_quiet     = ($urandom_range(0, 2) == 0);
            rx_mode_left = $urandom_range(50, 300);
         end else begin
            rx_mode_left--;
         end
         if (rx_gap > 0)
            rx_gap--;
         else if (!rx_quiet && (rsp_fire || $urandom_range(0, 15) == 0))
            rx_gap = idle_length();
         rsp_ready <= !hold_rsp && (rx_gap == 0);
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (accepted_count >= 70);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("deque_with_search_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      logic signed [DATA_W-1:0] back_word;
      int                       i;
      int                       burst;
      int                       push_pct;
      bit                       mid_drain_done;

      gen_quiet      = 1'b0;
      gen_drain      = 1'b0;
      gen_count      = 0;
      mid_drain_done = 1'b0;

      // directed: empty queue, dropped opcodes, wrap of the front slot,
      // first match among duplicates, dump and pops
      queue_request(OP_POP_FRONT, any_value());
      queue_request(OP_POP_BACK, any_value());
      queue_request(OP_DUMP, any_value());
      queue_request(OP_SEARCH, 32'sd0);
      queue_request(OP_SPARE_LO, 32'sd0);
      queue_request(OP_SPARE_HI, -32'sd1);
      queue_request(OP_PUSH_FRONT, 32'sh8000_0000);
      queue_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
      queue_request(OP_PUSH_FRONT, -32'sd1);
      queue_request(OP_PUSH_BACK, 32'sd0);
      queue_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
      queue_request(OP_SEARCH, 32'sh7FFF_FFFF);
      queue_request(OP_SEARCH, -32'sd1);
      queue_request(OP_SEARCH, 32'sh0000_5555);
      queue_request(OP_DUMP, 32'sh5555_5555);
      queue_request(OP_POP_FRONT, 32'shAAAA_AAAA);
      queue_request(OP_POP_BACK, 32'sh5555_5555);
      queue_request(OP_SPARE_HI, 32'sh1234_5678);
      queue_request(OP_DUMP, any_value());
      queue_request(OP_SEARCH, 32'sd0);
      for (i = 0; i < 4; i++) queue_request(OP_POP_BACK, any_value());

      // fill past capacity after a full drain, hit the back slot, dump it all
      gen_drain = 1'b1;
      back_word = '0;
      for (i = 0; i < 34; i++) begin
         queue_request(OP_PUSH_BACK, $urandom);
         if (i == CAPACITY - 1) back_word = pending_requests[$].value;
      end
      queue_request(OP_SEARCH, back_word);
      queue_request(OP_SEARCH, search_key());
      queue_request(OP_DUMP, any_value());

      // random bursts: fill, drain or mixed, some without idling
      while (gen_count < RANDOM_ITEMS) begin
         gen_quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       push_pct = PUSH_PCT_FILL;
            1:       push_pct = PUSH_PCT_DRAIN;
            default: push_pct = PUSH_PCT_MIXED;
         endcase
         burst = $urandom_range(8, 30);
         for (i = 0; i < burst; i++) begin
            if (!mid_drain_done && gen_count >= RANDOM_ITEMS / 2) begin
               gen_drain      = 1'b1;
               mid_drain_done = 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
               queue_request($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, any_value());
            queue_random_op(push_pct);
         end
      end

      // release reset at a falling edge
      reset = 1'b1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // wait for the last beat to go in and every result to come back
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("deque_with_search_tb: done, clean");
      else
         $display("deque_with_search_tb: done, errors");
      $finish;
   end

endmodule
